// ===== rtl/hsa_pkg.sv =====
// Package for the HSV saturation adjust block: fixed-point constants, pixel
// beat types and the hue sector codes. No dependencies.
package hsa_pkg;

  localparam int FracBits  = 16;
  localparam int ScaleW    = 12;
  localparam int DivSteps  = 4;
  localparam int DivStages = (FracBits + DivSteps - 1) / DivSteps;
  localparam int StepW     = $clog2(FracBits + DivSteps + 1);
  localparam int ChromaW   = 8 + FracBits;

  localparam logic [ScaleW-1:0]  SatScaleRst = ScaleW'(307);
  localparam logic [FracBits:0]  One         = (FracBits+1)'(1) << FracBits;

  typedef enum logic [2:0] {
    SecRedUp   = 3'd0,
    SecGrnUp   = 3'd1,
    SecGrnDn   = 3'd2,
    SecBluUp   = 3'd3,
    SecBluDn   = 3'd4,
    SecRedDn   = 3'd5
  } sector_e;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
  } pix_out_t;

endpackage

// ===== rtl/hsa_div_stage.sv =====
// One slice of the pipelined restoring divider: up to DivSteps quotient bits, plus the
// integer bit in the first slice. Depends on hsa_pkg.
module hsa_div_stage (
  input  logic                        first_i,
  input  logic [hsa_pkg::StepW-1:0]   base_i,
  input  logic [8:0]                  rem_i,
  input  logic [7:0]                  div_i,
  input  logic [hsa_pkg::FracBits:0]  quo_i,
  output logic [8:0]                  rem_o,
  output logic [hsa_pkg::FracBits:0]  quo_o
);
  import hsa_pkg::*;

  always_comb begin
    logic [8:0]        r;
    logic [8:0]        t;
    logic [FracBits:0] q;
    r = rem_i;
    q = quo_i;
    t = '0;
    // integer bit: numerator may equal the divisor
    if (first_i) begin
      if (r >= {1'b0, div_i}) begin
        r = r - {1'b0, div_i};
        q = {q[FracBits-1:0], 1'b1};
      end else begin
        q = {q[FracBits-1:0], 1'b0};
      end
    end
    for (int i = 0; i < DivSteps; i++) begin
      if (int'(base_i) + i < FracBits) begin
        t = {r[7:0], 1'b0};
        if (t >= {1'b0, div_i}) begin
          r = t - {1'b0, div_i};
          q = {q[FracBits-1:0], 1'b1};
        end else begin
          r = t;
          q = {q[FracBits-1:0], 1'b0};
        end
      end
    end
    rem_o = r;
    quo_o = q;
  end

endmodule

// ===== rtl/hsv_saturation_adjust_core.sv =====
// Top level of the HSV saturation adjust block: hue/saturation split, pipelined
// dividers, saturation scaling and RGB rebuild. Depends on hsa_pkg, hsa_div_stage.
//
// Usage:
//   Input beats (RGBA8) arrive on in_valid_i/in_data_i and are taken at an edge
//   where in_valid_i is high and in_stall_o low. Result beats leave on
//   out_valid_o/out_data_o and are taken when out_stall_i is low.
//   The saturation factor (unsigned Q4.8, 256 = unchanged) is written through
//   cfg_valid_i/cfg_data_i; cfg_ready_o is always high. Write it only while the
//   pipeline is empty.
//   Throughput: one pixel per clock while out_stall_i is low. The stages are one split
//   stage, one divider slice per four quotient bits, then scale, chroma, cross-term
//   multiply and output stages.
//   Each stage advances when it is empty or the stage after it advances, so
//   bubbles collapse and a stall on the output backs up only full stages; no
//   beat is lost or repeated.
//   Reset clears all valid bits and loads the factor with 307.
module hsv_saturation_adjust_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  hsa_pkg::pix_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output hsa_pkg::pix_out_t              out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [hsa_pkg::ScaleW-1:0]     cfg_data_i
);
  import hsa_pkg::*;

  typedef struct packed {
    logic [7:0]        mx;
    logic [7:0]        delta;
    sector_e           sector;
    logic [7:0]        alpha;
    logic [8:0]        sr;
    logic [FracBits:0] sq;
    logic [8:0]        fr;
    logic [FracBits:0] fq;
  } div_t;

  typedef struct packed {
    logic [7:0]          mx;
    sector_e             sector;
    logic [7:0]          alpha;
    logic [FracBits:0]   s2;
    logic [FracBits-1:0] frac;
  } scl_t;

  typedef struct packed {
    logic [7:0]         mx;
    sector_e            sector;
    logic [7:0]         alpha;
    logic [ChromaW-1:0] c;
    logic [ChromaW-1:0] m;
    logic [FracBits:0]  fe;
  } chr_t;

  typedef struct packed {
    logic [7:0]         mx;
    sector_e            sector;
    logic [7:0]         alpha;
    logic [ChromaW-1:0] x;
    logic [ChromaW-1:0] m;
  } crs_t;

  logic [ScaleW-1:0] sat_scale_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_scale_q <= SatScaleRst;
    end else if (cfg_valid_i) begin
      sat_scale_q <= cfg_data_i;
    end
  end

  // ---- stage enables, from the output back
  logic              dv_q [DivStages+1];
  logic              dv_en [DivStages+1];
  logic              ev_q, fv_q, gv_q, hv_q;
  logic              en_e, en_f, en_g, en_h;

  assign en_h = !hv_q || !out_stall_i;
  assign en_g = !gv_q || en_h;
  assign en_f = !fv_q || en_g;
  assign en_e = !ev_q || en_f;

  always_comb begin
    dv_en[DivStages] = !dv_q[DivStages] || en_e;
    for (int k = DivStages - 1; k >= 0; k--) begin
      dv_en[k] = !dv_q[k] || dv_en[k+1];
    end
  end

  assign in_stall_o = !dv_en[0];

  // ---- split stage: value, spread, hue sector and remainder
  div_t dp_d [DivStages+1];
  div_t dp_q [DivStages+1];

  always_comb begin
    logic [7:0]  r, g, b, mx, mn, dl, hrem;
    logic [10:0] n, d11, sd;
    logic [2:0]  sec;
    r   = in_data_i.red_in;
    g   = in_data_i.green_in;
    b   = in_data_i.blue_in;
    mx  = (r > g) ? r : g;
    mx  = (mx > b) ? mx : b;
    mn  = (r < g) ? r : g;
    mn  = (mn < b) ? mn : b;
    dl  = mx - mn;
    d11 = {3'b000, dl};
    if (mx == r) begin
      n = (g >= b) ? {3'b000, g - b} : 11'd6 * d11 - {3'b000, b - g};
    end else if (mx == g) begin
      n = 11'd2 * d11 + {3'b000, b} - {3'b000, r};
    end else begin
      n = 11'd4 * d11 + {3'b000, r} - {3'b000, g};
    end
    sec = 3'd0;
    for (int k = 1; k <= 5; k++) begin
      if (n >= 11'(k) * d11) sec = 3'(k);
    end
    sd = 11'(sec) * d11;
    hrem = 8'(n - sd);
    if (dl == 8'd0) begin
      sec  = 3'd0;
      hrem = 8'd0;
    end
    dp_d[0].mx     = mx;
    dp_d[0].delta  = dl;
    dp_d[0].sector = sector_e'(sec);
    dp_d[0].alpha  = in_data_i.alpha_in;
    dp_d[0].sr     = {1'b0, dl};
    dp_d[0].sq     = '0;
    dp_d[0].fr     = {1'b0, hrem};
    dp_d[0].fq     = '0;
  end

  // ---- divider slices: s = (delta << F) / max, frac = (rem << F) / delta
  for (genvar k = 1; k <= DivStages; k++) begin : g_div
    localparam logic [StepW-1:0] Base = StepW'((k - 1) * DivSteps);
    logic       first;
    assign first = (k == 1);

    hsa_div_stage u_sat_div (
      .first_i (first),
      .base_i  (Base),
      .rem_i   (dp_q[k-1].sr),
      .div_i   (dp_q[k-1].mx),
      .quo_i   (dp_q[k-1].sq),
      .rem_o   (dp_d[k].sr),
      .quo_o   (dp_d[k].sq)
    );

    hsa_div_stage u_hue_div (
      .first_i (first),
      .base_i  (Base),
      .rem_i   (dp_q[k-1].fr),
      .div_i   (dp_q[k-1].delta),
      .quo_i   (dp_q[k-1].fq),
      .rem_o   (dp_d[k].fr),
      .quo_o   (dp_d[k].fq)
    );

    assign dp_d[k].mx     = dp_q[k-1].mx;
    assign dp_d[k].delta  = dp_q[k-1].delta;
    assign dp_d[k].sector = dp_q[k-1].sector;
    assign dp_d[k].alpha  = dp_q[k-1].alpha;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DivStages; k++) dv_q[k] <= 1'b0;
    end else begin
      if (dv_en[0]) dv_q[0] <= in_valid_i;
      for (int k = 1; k <= DivStages; k++) begin
        if (dv_en[k]) dv_q[k] <= dv_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_en[0] && in_valid_i) dp_q[0] <= dp_d[0];
    for (int k = 1; k <= DivStages; k++) begin
      if (dv_en[k] && dv_q[k-1]) dp_q[k] <= dp_d[k];
    end
  end

  // ---- scale stage: s2 = min(1, s * factor / 256)
  scl_t e_d, e_q;

  always_comb begin
    logic [FracBits:0]        s;
    logic [FracBits+ScaleW:0] prod;
    logic [FracBits+ScaleW:0] sh;
    div_t                     dl;
    dl   = dp_q[DivStages];
    s    = (dl.delta == 8'd0) ? '0 : dl.sq;
    prod = (FracBits+ScaleW+1)'(s) * (FracBits+ScaleW+1)'(sat_scale_q);
    sh   = prod >> 8;
    e_d.s2     = (sh > (FracBits+ScaleW+1)'(One)) ? One : sh[FracBits:0];
    e_d.frac   = (dl.delta == 8'd0) ? '0 : dl.fq[FracBits-1:0];
    e_d.mx     = dl.mx;
    e_d.sector = dl.sector;
    e_d.alpha  = dl.alpha;
  end

  // ---- chroma stage
  chr_t f_d, f_q;

  always_comb begin
    logic [ChromaW-1:0] c;
    c = ChromaW'(ChromaW'(e_q.mx) * ChromaW'(e_q.s2));
    f_d.c      = c;
    f_d.m      = ({e_q.mx, {FracBits{1'b0}}}) - c;
    f_d.fe     = e_q.sector[0] ? One - {1'b0, e_q.frac} : {1'b0, e_q.frac};
    f_d.mx     = e_q.mx;
    f_d.sector = e_q.sector;
    f_d.alpha  = e_q.alpha;
  end

  // ---- cross term: x = c * fe >> F, where fe is frac or 1 - frac by sector
  crs_t g_d, g_q;

  always_comb begin
    logic [ChromaW+FracBits:0] px;
    px = (ChromaW+FracBits+1)'(f_q.c) * (ChromaW+FracBits+1)'(f_q.fe);
    g_d.x      = ChromaW'(px >> FracBits);
    g_d.m      = f_q.m;
    g_d.mx     = f_q.mx;
    g_d.sector = f_q.sector;
    g_d.alpha  = f_q.alpha;
  end

  // ---- rebuild RGB by sector
  pix_out_t h_d, h_q;

  always_comb begin
    logic [ChromaW-1:0] xm;
    logic [7:0]         hi, mid, lo;
    xm  = g_q.x + g_q.m;
    hi  = g_q.mx;
    mid = xm[FracBits +: 8];
    lo  = g_q.m[FracBits +: 8];
    case (g_q.sector)
      SecRedUp: begin h_d.red_out = hi;  h_d.green_out = mid; h_d.blue_out = lo;  end
      SecGrnUp: begin h_d.red_out = mid; h_d.green_out = hi;  h_d.blue_out = lo;  end
      SecGrnDn: begin h_d.red_out = lo;  h_d.green_out = hi;  h_d.blue_out = mid; end
      SecBluUp: begin h_d.red_out = lo;  h_d.green_out = mid; h_d.blue_out = hi;  end
      SecBluDn: begin h_d.red_out = mid; h_d.green_out = lo;  h_d.blue_out = hi;  end
      default:  begin h_d.red_out = hi;  h_d.green_out = lo;  h_d.blue_out = mid; end
    endcase
    h_d.alpha_out = g_q.alpha;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q <= 1'b0;
      fv_q <= 1'b0;
      gv_q <= 1'b0;
      hv_q <= 1'b0;
    end else begin
      if (en_e) ev_q <= dv_q[DivStages];
      if (en_f) fv_q <= ev_q;
      if (en_g) gv_q <= fv_q;
      if (en_h) hv_q <= gv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_e && dv_q[DivStages]) e_q <= e_d;
    if (en_f && ev_q) f_q <= f_d;
    if (en_g && fv_q) g_q <= g_d;
    if (en_h && gv_q) h_q <= h_d;
  end

  assign out_valid_o = hv_q;
  assign out_data_o  = h_q;

endmodule
